// ===== rtl/core/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants for the texture span painter.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int CoordW     = 32;
  localparam int PixAddrW   = 24;
  localparam int MemAddrW   = 16;
  localparam int ByteW      = 8;
  localparam int LenW       = 11;
  localparam int MaskW      = 12;
  localparam int FloorW     = 3;
  localparam int StrideW    = 13;
  localparam int InDataW    = 200;
  localparam int InUserW    = 2;
  localparam int OutDataW   = 40;
  localparam int CfgAddrW   = 2;
  localparam int CfgDataW   = 16;
  localparam int LutDepth   = 65536;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;
  localparam int OutDepth   = 4;
  localparam int OutPtrW    = 2;
  localparam int OutCntW    = 3;

  localparam logic [MaskW-1:0]    WallMaskRst  = 12'd4095;
  localparam logic [FloorW-1:0]   FloorLog2Rst = 3'd6;
  localparam logic [StrideW-1:0]  StrideRst    = 13'd320;
  localparam logic [MemAddrW-1:0] ShadeBaseRst = 16'd0;

  typedef enum logic [1:0] {
    ACT_LOAD_TEX = 2'd0,
    ACT_LOAD_LUT = 2'd1,
    ACT_SPAN     = 2'd2,
    ACT_PIXEL    = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    SPAN_WALL   = 2'd0,
    SPAN_OBJECT = 2'd1,
    SPAN_FLOOR  = 2'd2,
    SPAN_NONE   = 2'd3
  } span_e;

  typedef enum logic [1:0] {
    DRAW_PLAIN  = 2'd0,
    DRAW_MASKED = 2'd1,
    DRAW_TRANS  = 2'd2
  } draw_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_WALL_MASK  = 2'd0,
    CFG_FLOOR_LOG2 = 2'd1,
    CFG_STRIDE     = 2'd2,
    CFG_SHADE_BASE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [MaskW-1:0]    wall_mask;
    logic [FloorW-1:0]   floor_log2;
    logic [StrideW-1:0]  stride;
    logic [MemAddrW-1:0] shade_base;
  } cfg_t;

  typedef struct packed {
    act_e                action;
    logic [MemAddrW-1:0] mem_address;
    logic [ByteW-1:0]    mem_data;
    logic [CoordW-1:0]   start_u;
    logic [CoordW-1:0]   start_v;
    logic [CoordW-1:0]   step_u;
    logic [CoordW-1:0]   step_v;
    logic [PixAddrW-1:0] pixel_base;
    logic [LenW-1:0]     span_length;
    logic [1:0]          span_kind;
    logic [1:0]          draw_kind;
    logic [ByteW-1:0]    dest_pixel;
  } in_item_t;

  // Command word handed from the span walker to the pixel back end.
  typedef struct packed {
    act_e                kind;      // load texel, load entry or pixel
    logic [MemAddrW-1:0] mem_addr;  // load address or texel index
    logic [ByteW-1:0]    data;      // load byte or framebuffer value
    draw_e               draw;
    logic [PixAddrW-1:0] pix_addr;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic [PixAddrW-1:0] pixel_address;
    logic [ByteW-1:0]    pixel_value;
    logic                write_enable;
    logic                last;
  } out_t;

endpackage

// ===== rtl/core/tsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_front
// Span walker: takes input words, tracks the running span and turns each
// pixel step into a command with texel index and framebuffer address.
// ----------------------------------------------------------------------------
module tsp_front
  import tsp_pkg::*;
#(
  parameter int MAX_SPAN_BITS = 11
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output cmd_t     push_cmd_o
);

  logic [CoordW-1:0]        coord_u_q, coord_u_d, coord_v_q, coord_v_d;
  logic [CoordW-1:0]        delta_u_q, delta_u_d, delta_v_q, delta_v_d;
  logic [MAX_SPAN_BITS-1:0] left_q, left_d;
  logic [PixAddrW-1:0]      addr_q, addr_d;
  span_e                    span_q, span_d;
  draw_e                    draw_q, draw_d;

  logic                accept;
  logic                in_span;
  logic [15:0]         iu, iv, fmask, tex_idx;
  logic [PixAddrW-1:0] addr_step;
  draw_e               new_draw;
  span_e               new_span;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_span    = (left_q != '0);

  assign iu    = coord_u_q[CoordW-1:16];
  assign iv    = coord_v_q[CoordW-1:16];
  assign fmask = ~(16'hFFFF << cfg_i.floor_log2);

  // Texel index before trimming to the store width.
  always_comb begin
    case (span_q)
      SPAN_WALL:   tex_idx = iu & 16'(cfg_i.wall_mask);
      SPAN_OBJECT: tex_idx = iu;
      default:     tex_idx = ((iv & fmask) << cfg_i.floor_log2) + (iu & fmask);
    endcase
  end

  assign addr_step = (span_q == SPAN_FLOOR) ? PixAddrW'(1) : PixAddrW'(cfg_i.stride);

  assign new_span = span_e'(in_item_i.span_kind);

  // Floor spans and unused codes draw plain.
  always_comb begin
    new_draw = DRAW_PLAIN;
    if (new_span != SPAN_FLOOR) begin
      case (draw_e'(in_item_i.draw_kind))
        DRAW_MASKED: new_draw = DRAW_MASKED;
        DRAW_TRANS:  new_draw = DRAW_TRANS;
        default:     new_draw = DRAW_PLAIN;
      endcase
    end
  end

  always_comb begin
    coord_u_d = coord_u_q;
    coord_v_d = coord_v_q;
    delta_u_d = delta_u_q;
    delta_v_d = delta_v_q;
    left_d    = left_q;
    addr_d    = addr_q;
    span_d    = span_q;
    draw_d    = draw_q;
    push_o    = 1'b0;

    push_cmd_o.kind     = in_item_i.action;
    push_cmd_o.mem_addr = in_item_i.mem_address;
    push_cmd_o.data     = in_item_i.mem_data;
    push_cmd_o.draw     = draw_q;
    push_cmd_o.pix_addr = addr_q;
    push_cmd_o.last     = (left_q == MAX_SPAN_BITS'(1));

    if (accept) begin
      case (in_item_i.action)
        ACT_LOAD_TEX, ACT_LOAD_LUT: begin
          push_o = 1'b1;
        end
        ACT_SPAN: begin
          coord_u_d = in_item_i.start_u;
          coord_v_d = in_item_i.start_v;
          delta_u_d = in_item_i.step_u;
          delta_v_d = in_item_i.step_v;
          addr_d    = in_item_i.pixel_base;
          span_d    = new_span;
          draw_d    = new_draw;
          left_d    = (new_span == SPAN_NONE) ? '0
                                              : MAX_SPAN_BITS'(in_item_i.span_length);
        end
        default: begin
          if (in_span) begin
            push_o              = 1'b1;
            push_cmd_o.mem_addr = tex_idx;
            push_cmd_o.data     = in_item_i.dest_pixel;
            coord_u_d           = coord_u_q + delta_u_q;
            coord_v_d           = coord_v_q + delta_v_q;
            addr_d              = addr_q + addr_step;
            left_d              = left_q - MAX_SPAN_BITS'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_u_q <= '0;
      coord_v_q <= '0;
      delta_u_q <= '0;
      delta_v_q <= '0;
      left_q    <= '0;
      addr_q    <= '0;
      span_q    <= SPAN_WALL;
      draw_q    <= DRAW_PLAIN;
    end else begin
      coord_u_q <= coord_u_d;
      coord_v_q <= coord_v_d;
      delta_u_q <= delta_u_d;
      delta_v_q <= delta_v_d;
      left_q    <= left_d;
      addr_q    <= addr_d;
      span_q    <= span_d;
      draw_q    <= draw_d;
    end
  end

endmodule

// ===== rtl/core/tsp_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_cmd_queue
// Short command FIFO between the span walker and the pixel back end.
// ----------------------------------------------------------------------------
module tsp_cmd_queue
  import tsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_back
// Pixel back end: texture store access, table lookup and output buffer.
// Stage 1 reads or writes the texture store, stage 2 the lookup table.
// ----------------------------------------------------------------------------
module tsp_back
  import tsp_pkg::*;
#(
  parameter int TEXTURE_ADDR_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic out_valid_o,
  output out_t out_o,
  input  logic out_ready_i
);

  localparam int TexDepth = 1 << TEXTURE_ADDR_BITS;

  logic                 s1_v_q, s2_v_q;
  cmd_t                 s1_cmd_q;
  logic [PixAddrW-1:0]  s2_addr_q;
  logic                 s2_zero_q, s2_last_q;
  logic                 s2_zero_d;

  logic                 tex_we;
  logic [ByteW-1:0]     texel;
  logic                 lut_we;
  logic [MemAddrW-1:0]  lut_addr;
  logic [ByteW-1:0]     lut_rdata;

  out_t                 out_q [OutDepth];
  logic [OutPtrW-1:0]   out_wr_q, out_rd_q;
  logic [OutCntW-1:0]   out_cnt_q;
  logic                 out_push, out_pop;
  out_t                 out_new;

  // Only take a command when the output buffer has room for everything
  // already in flight, so the two stages never stall.
  assign cmd_pop_o = cmd_valid_i &&
                     ((4'(out_cnt_q) + 4'(s1_v_q) + 4'(s2_v_q)) < 4'(OutDepth));

  assign tex_we = cmd_pop_o && (cmd_i.kind == ACT_LOAD_TEX);

  tsp_ram #(
    .Width (ByteW),
    .Depth (TexDepth)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .addr_i  (cmd_i.mem_addr[TEXTURE_ADDR_BITS-1:0]),
    .wdata_i (cmd_i.data),
    .rdata_o (texel)
  );

  assign lut_we = s1_v_q && (s1_cmd_q.kind == ACT_LOAD_LUT);

  always_comb begin
    if (s1_cmd_q.kind == ACT_LOAD_LUT) begin
      lut_addr = s1_cmd_q.mem_addr;
    end else if (s1_cmd_q.draw == DRAW_TRANS) begin
      lut_addr = {texel, s1_cmd_q.data};
    end else begin
      lut_addr = cfg_i.shade_base + MemAddrW'(texel);
    end
  end

  assign s2_zero_d = (s1_cmd_q.draw == DRAW_MASKED) && (texel == '0);

  tsp_ram #(
    .Width (ByteW),
    .Depth (LutDepth)
  ) u_lut_ram (
    .clk_i   (clk_i),
    .we_i    (lut_we),
    .addr_i  (lut_addr),
    .wdata_i (s1_cmd_q.data),
    .rdata_o (lut_rdata)
  );

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= cmd_i;
    s2_addr_q <= s1_cmd_q.pix_addr;
    s2_zero_q <= s2_zero_d;
    s2_last_q <= s1_cmd_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_pop_o;
      s2_v_q <= s1_v_q && (s1_cmd_q.kind == ACT_PIXEL);
    end
  end

  // Output buffer.
  assign out_new.pixel_address = s2_addr_q;
  assign out_new.pixel_value   = s2_zero_q ? '0 : lut_rdata;
  assign out_new.write_enable  = !s2_zero_q;
  assign out_new.last          = s2_last_q;

  assign out_push    = s2_v_q;
  assign out_valid_o = (out_cnt_q != '0);
  assign out_o       = out_q[out_rd_q];
  assign out_pop     = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_q[out_wr_q] <= out_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (out_push) begin
        out_wr_q <= out_wr_q + OutPtrW'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + OutPtrW'(1);
      end
      if (out_push && !out_pop) begin
        out_cnt_q <= out_cnt_q + OutCntW'(1);
      end else if (out_pop && !out_push) begin
        out_cnt_q <= out_cnt_q - OutCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/texture_span_painter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_span_painter_top
// Affine 16.16 texture span painter with loadable texture store and table.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word per command; tuser selects load texel, load
//   table entry, start span or pixel step. Each pixel step inside a span
//   yields one word on m_axis: framebuffer address, value, write enable,
//   with tlast on the final pixel of the span. Loads, span starts and pixel
//   steps outside a span yield nothing.
//   Throughput is one word per cycle on both sides while neither side stalls.
//   A pixel word passes through the command queue, texture store read, table
//   read and output buffer before it leaves on m_axis.
//   The cfg port writes one register per cycle with cfg_we_i; write it only
//   while no word is in flight.
//   Reset clears the span state and the queues and loads the register
//   defaults; the texture store and table hold no defined data until loaded.
//   When m_axis stalls, the 4-word output buffer fills first, then the
//   4-word command queue, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module texture_span_painter_top
  import tsp_pkg::*;
#(
  parameter int TEXTURE_ADDR_BITS = 12,
  parameter int MAX_SPAN_BITS     = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // mem_address, mem_data, start_u, start_v, step_u, step_v, pixel_base,
  // span_length, span_kind, draw_kind, dest_pixel, one zero pad bit
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_address, pixel_value, write_enable, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t     cfg_q;
  in_item_t in_item;
  logic     q_full, q_valid, q_pop, push;
  cmd_t     push_cmd, q_head;
  out_t     out_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_mask  <= WallMaskRst;
      cfg_q.floor_log2 <= FloorLog2Rst;
      cfg_q.stride     <= StrideRst;
      cfg_q.shade_base <= ShadeBaseRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_WALL_MASK:  cfg_q.wall_mask  <= cfg_wdata_i[MaskW-1:0];
        CFG_FLOOR_LOG2: cfg_q.floor_log2 <= cfg_wdata_i[FloorW-1:0];
        CFG_STRIDE:     cfg_q.stride     <= cfg_wdata_i[StrideW-1:0];
        CFG_SHADE_BASE: cfg_q.shade_base <= cfg_wdata_i[MemAddrW-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  assign in_item.action      = act_e'(s_axis_tuser);
  assign in_item.mem_address = s_axis_tdata[15:0];
  assign in_item.mem_data    = s_axis_tdata[23:16];
  assign in_item.start_u     = s_axis_tdata[55:24];
  assign in_item.start_v     = s_axis_tdata[87:56];
  assign in_item.step_u      = s_axis_tdata[119:88];
  assign in_item.step_v      = s_axis_tdata[151:120];
  assign in_item.pixel_base  = s_axis_tdata[175:152];
  assign in_item.span_length = s_axis_tdata[186:176];
  assign in_item.span_kind   = s_axis_tdata[188:187];
  assign in_item.draw_kind   = s_axis_tdata[190:189];
  assign in_item.dest_pixel  = s_axis_tdata[198:191];

  tsp_front #(
    .MAX_SPAN_BITS (MAX_SPAN_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .queue_full_i (q_full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  tsp_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  tsp_back #(
    .TEXTURE_ADDR_BITS (TEXTURE_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_o       (out_word),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_word.write_enable, out_word.pixel_value,
                         out_word.pixel_address};
  assign m_axis_tlast = out_word.last;

endmodule

// ===== sim/tb_texture_span_painter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_texture_span_painter_top
// Self-checking bench for the texture span painter.
// Loads, span starts and pixel steps are built into a send queue while a
// built-in span predictor computes the expected framebuffer writes. A
// stream driver and a monitor run with random gaps on both sides. Register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_texture_span_painter_top;
  import tsp_pkg::*;

  localparam int TexBits  = 12;
  localparam int TexDepth = 1 << TexBits;
  localparam int Phases   = 6;
  localparam int RandWords = 100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  texture_span_painter_top #(
    .TEXTURE_ADDR_BITS(TexBits),
    .MAX_SPAN_BITS    (LenW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: span walker, registers and shadow memories.
  logic [CoordW-1:0]   cu, cv, du, dv;
  logic [LenW-1:0]     left;
  logic [PixAddrW-1:0] naddr;
  span_e               skind;
  logic [1:0]          dkind;
  logic [MaskW-1:0]    p_mask;
  logic [FloorW-1:0]   p_flog2;
  logic [StrideW-1:0]  p_stride;
  logic [MemAddrW-1:0] p_shade;
  logic [ByteW-1:0]    tex_mem [TexDepth];
  bit                  tex_known [TexDepth];
  logic [ByteW-1:0]    lut_mem [LutDepth];
  bit                  lut_known [LutDepth];

  in_item_t words_to_send [$];
  out_t     pixel_writes_due [$];
  out_t     seen, due;

  int  send_idle_pct, recv_idle_pct;
  int  fail_count, words_accepted, pixels_checked;
  bit  s_fire;

  // Texel index for the current coordinate, per span kind.
  function automatic logic [TexBits-1:0] texel_addr();
    logic [15:0] iu, iv, m;
    logic [31:0] idx;
    iu = cu[31:16];
    iv = cv[31:16];
    m  = (16'd1 << p_flog2) - 16'd1;
    case (skind)
      SPAN_WALL:   idx = 32'(iu & 16'(p_mask));
      SPAN_OBJECT: idx = 32'(iu);
      default:     idx = (32'(iv & m) << p_flog2) + 32'(iu & m);
    endcase
    return idx[TexBits-1:0];
  endfunction

  function automatic logic [InDataW-1:0] pack_word(in_item_t it);
    return {1'b0, it.dest_pixel, it.draw_kind, it.span_kind, it.span_length, it.pixel_base,
            it.step_v, it.step_u, it.start_v, it.start_u, it.mem_data, it.mem_address};
  endfunction

  function automatic in_item_t noise_item(act_e a);
    in_item_t it;
    it.action      = a;
    it.mem_address = 16'($urandom);
    it.mem_data    = 8'($urandom);
    it.start_u     = $urandom;
    it.start_v     = $urandom;
    it.step_u      = $urandom;
    it.step_v      = $urandom;
    it.pixel_base  = 24'($urandom);
    it.span_length = 11'($urandom);
    it.span_kind   = 2'($urandom);
    it.draw_kind   = 2'($urandom);
    it.dest_pixel  = 8'($urandom);
    return it;
  endfunction

  // Advance the predictor by one input word; pixel steps inside a span
  // leave one expected framebuffer write.
  task automatic span_predict(input in_item_t it);
    logic [ByteW-1:0]    tx;
    logic [MemAddrW-1:0] li;
    out_t                o;
    case (it.action)
      ACT_LOAD_TEX: begin
        tex_mem[it.mem_address[TexBits-1:0]]   = it.mem_data;
        tex_known[it.mem_address[TexBits-1:0]] = 1'b1;
      end
      ACT_LOAD_LUT: begin
        lut_mem[it.mem_address]   = it.mem_data;
        lut_known[it.mem_address] = 1'b1;
      end
      ACT_SPAN: begin
        cu    = it.start_u;
        cv    = it.start_v;
        du    = it.step_u;
        dv    = it.step_v;
        naddr = it.pixel_base;
        skind = span_e'(it.span_kind);
        dkind = it.draw_kind;
        left  = (skind == SPAN_NONE) ? '0 : it.span_length;
      end
      default: begin
        if (left != 0) begin
          tx = tex_mem[texel_addr()];
          o.write_enable = 1'b1;
          if (skind != SPAN_FLOOR && dkind == DRAW_TRANS) begin
            o.pixel_value = lut_mem[{tx, it.dest_pixel}];
          end else if (skind != SPAN_FLOOR && dkind == DRAW_MASKED && tx == 0) begin
            o.pixel_value  = '0;
            o.write_enable = 1'b0;
          end else begin
            li = p_shade + 16'(tx);
            o.pixel_value = lut_mem[li];
          end
          o.pixel_address = naddr;
          o.last = (left == 1);
          pixel_writes_due.push_back(o);
          naddr = naddr + ((skind == SPAN_FLOOR) ? 24'd1 : 24'(p_stride));
          cu = cu + du;
          cv = cv + dv;
          left = left - 1'b1;
        end
      end
    endcase
  endtask

  task automatic push_word(input in_item_t it);
    words_to_send.push_back(it);
    span_predict(it);
  endtask

  task automatic load_texel(input logic [15:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item(ACT_LOAD_TEX);
    it.mem_address = addr;
    it.mem_data = data;
    push_word(it);
  endtask

  task automatic load_entry(input logic [15:0] addr, input logic [7:0] data);
    in_item_t it;
    it = noise_item(ACT_LOAD_LUT);
    it.mem_address = addr;
    it.mem_data = data;
    push_word(it);
  endtask

  task automatic start_span(input logic [31:0] u, v, su, sv, input logic [23:0] base,
                            input logic [10:0] len, input span_e sk, input logic [1:0] dk);
    in_item_t it;
    it = noise_item(ACT_SPAN);
    it.start_u = u;
    it.start_v = v;
    it.step_u = su;
    it.step_v = sv;
    it.pixel_base = base;
    it.span_length = len;
    it.span_kind = sk;
    it.draw_kind = dk;
    push_word(it);
  endtask

  // Pixel step; any store entry it would read that was never loaded gets
  // loaded just ahead of it, mid-span.
  task automatic send_pixel(input logic [7:0] dest);
    in_item_t          it;
    logic [TexBits-1:0] ti;
    logic [7:0]        tx;
    logic [15:0]       li;
    bit                needs_lut;
    it = noise_item(ACT_PIXEL);
    it.dest_pixel = dest;
    if (left != 0) begin
      ti = texel_addr();
      if (!tex_known[ti])
        load_texel({4'($urandom), ti}, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom));
      tx = tex_mem[ti];
      needs_lut = 1'b1;
      li = p_shade + 16'(tx);
      if (skind != SPAN_FLOOR && dkind == DRAW_TRANS) li = {tx, dest};
      else if (skind != SPAN_FLOOR && dkind == DRAW_MASKED && tx == 0) needs_lut = 1'b0;
      if (needs_lut && !lut_known[li]) load_entry(li, 8'($urandom));
    end
    push_word(it);
  endtask

  task automatic random_span();
    span_e       sk;
    logic [10:0] len;
    logic [31:0] su, sv;
    int          r;
    r = $urandom_range(0, 19);
    if (r < 6) sk = SPAN_WALL;
    else if (r < 12) sk = SPAN_OBJECT;
    else if (r < 19) sk = SPAN_FLOOR;
    else sk = SPAN_NONE;
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r < 3) len = 11'($urandom) | 11'h400;  // long span, cut short by the next start
    else len = 11'($urandom_range(1, 12));
    if ($urandom_range(0, 1) == 0) begin
      su = $urandom;
      sv = $urandom;
    end else begin
      su = 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
      sv = 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
    end
    start_span($urandom, $urandom, su, sv, 24'($urandom), len, sk, 2'($urandom));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WALL_MASK:  p_mask   = val[MaskW-1:0];
      CFG_FLOOR_LOG2: p_flog2  = val[FloorW-1:0];
      CFG_STRIDE:     p_stride = val[StrideW-1:0];
      default:        p_shade  = val;
    endcase
  endtask

  // Drain the send queue and all expected writes, then cover pipeline latency.
  task automatic settle();
    while (words_to_send.size() != 0 || s_axis_tvalid || pixel_writes_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Input driver
  always @(posedge clk_i) begin
    s_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) words_accepted <= words_accepted + 1;
  end

  always @(negedge clk_i) begin
    if (s_fire) void'(words_to_send.pop_front());
    if (s_axis_tvalid && !s_fire) begin
      // word still waiting for tready: hold it
    end else if (rst_ni && words_to_send.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pack_word(words_to_send[0]);
      s_axis_tuser  <= words_to_send[0].action;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Output side: random backpressure, checking in order
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.pixel_address = m_axis_tdata[PixAddrW-1:0];
      seen.pixel_value   = m_axis_tdata[PixAddrW +: ByteW];
      seen.write_enable  = m_axis_tdata[PixAddrW+ByteW];
      seen.last          = m_axis_tlast;
      if (pixel_writes_due.size() == 0) begin
        $display("%0t unexpected word: none expected, got addr %h val %h we %b last %b",
                 $time, seen.pixel_address, seen.pixel_value, seen.write_enable, seen.last);
        fail_count++;
      end else begin
        due = pixel_writes_due.pop_front();
        pixels_checked++;
        if (due !== seen) begin
          $display({"%0t mismatch: expected addr %h val %h we %b last %b,",
                    " got addr %h val %h we %b last %b"},
                   $time, due.pixel_address, due.pixel_value, due.write_enable, due.last,
                   seen.pixel_address, seen.pixel_value, seen.write_enable, seen.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("%0t timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase, n, pick;
    cu = '0; cv = '0; du = '0; dv = '0;
    left = '0; naddr = '0;
    skind = SPAN_WALL; dkind = DRAW_PLAIN;
    p_mask = WallMaskRst; p_flog2 = FloorLog2Rst;
    p_stride = StrideRst; p_shade = ShadeBaseRst;
    fail_count = 0; words_accepted = 0; pixels_checked = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    for (phase = 0; phase < Phases; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 20; recv_idle_pct = 72;
      end else if (phase < 4) begin
        send_idle_pct = 72; recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case (phase)
        1: begin
          write_reg(CFG_WALL_MASK, 16'd0);
          write_reg(CFG_FLOOR_LOG2, 16'd0);
          write_reg(CFG_STRIDE, 16'd1);
          write_reg(CFG_SHADE_BASE, 16'hFF00);
        end
        2: begin
          write_reg(CFG_WALL_MASK, 16'h0FFF);
          write_reg(CFG_FLOOR_LOG2, 16'd7);  // above six: floor index wraps
          write_reg(CFG_STRIDE, 16'd4096);
          write_reg(CFG_SHADE_BASE, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_WALL_MASK, 16'($urandom));
          write_reg(CFG_FLOOR_LOG2, 16'hFFFA);
          write_reg(CFG_STRIDE, 16'd0);
          write_reg(CFG_SHADE_BASE, 16'($urandom));
        end
        4: begin
          write_reg(CFG_WALL_MASK, 16'h00F0);
          write_reg(CFG_FLOOR_LOG2, 16'd3);
          write_reg(CFG_STRIDE, 16'hFFFF);
          write_reg(CFG_SHADE_BASE, 16'd0);
        end
        5: begin
          write_reg(CFG_WALL_MASK, 16'd4095);
          write_reg(CFG_FLOOR_LOG2, 16'd6);
          write_reg(CFG_STRIDE, 16'd320);
          write_reg(CFG_SHADE_BASE, 16'($urandom_range(0, 255)) << 8);
        end
        default: ;
      endcase

      if (phase == 0) begin
        // coordinate extremes, address wrap past 24 bits
        start_span(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF,
                   11'd3, SPAN_WALL, DRAW_PLAIN);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h5A);
        send_pixel(8'h11);  // span already done
        // masked object on a zero texel, loaded through a wrapped address
        load_texel(16'hF123, 8'h00);
        start_span(32'h0123_8000, 32'h0, 32'h0, 32'h0, 24'h000100, 11'd2,
                   SPAN_OBJECT, DRAW_MASKED);
        send_pixel(8'h33);
        send_pixel(8'hCC);
        start_span(32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, 32'h0, 24'h0, 11'd2,
                   SPAN_WALL, DRAW_TRANS);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        // floor ignores the masked draw kind
        start_span(32'h0005_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 24'h00FFFE,
                   11'd3, SPAN_FLOOR, DRAW_MASKED);
        send_pixel(8'h01);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        start_span($urandom, $urandom, $urandom, $urandom, 24'h123456, 11'd1,
                   SPAN_OBJECT, 2'd3);
        send_pixel(8'h42);
        // empty spans: kind three and zero length
        start_span($urandom, $urandom, $urandom, $urandom, 24'h0, 11'd5, SPAN_NONE, DRAW_PLAIN);
        send_pixel(8'h24);
        start_span($urandom, $urandom, $urandom, $urandom, 24'h0, 11'd0, SPAN_WALL, DRAW_PLAIN);
        send_pixel(8'h24);
        // full-length span cut short by a new start
        start_span($urandom, $urandom, $urandom, $urandom, 24'h000A00, 11'h7FF,
                   SPAN_WALL, DRAW_PLAIN);
        send_pixel(8'h10);
        send_pixel(8'h20);
        start_span($urandom, $urandom, $urandom, $urandom, 24'hFFFF00, 11'd1,
                   SPAN_FLOOR, DRAW_TRANS);
        send_pixel(8'h30);
      end

      for (n = 0; n < RandWords; n++) begin
        pick = $urandom_range(0, 99);
        if (left == 0) begin
          if (pick < 75) random_span();
          else send_pixel(8'($urandom));
        end else if (pick < 6) begin
          random_span();
        end else if (pick < 10) begin
          load_texel(16'($urandom), 8'($urandom));
        end else if (pick < 14) begin
          load_entry(16'($urandom), 8'($urandom));
        end else begin
          send_pixel(8'($urandom));
        end
      end
      settle();
    end

    $display("%0d words sent across %0d register settings, %0d pixel writes checked",
             words_accepted, Phases, pixels_checked);
    $display("wall, object and floor spans with plain, masked and translucent draws");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tsp_pkg.sv
rtl/core/tsp_ram.sv
rtl/core/tsp_front.sv
rtl/core/tsp_cmd_queue.sv
rtl/core/tsp_back.sv
rtl/core/texture_span_painter_top.sv
sim/tb_texture_span_painter_top.sv
